>>> src/cgbm_pkg.sv
// ----------------------------------------------------------------------------
// cgbm_pkg
// Shared types and constants for the correlated GBM path step block.
// ----------------------------------------------------------------------------
package cgbm_pkg;

    localparam int ASSET_W   = 2;
    localparam int NORMALS   = 4;    // normals carried by one step request
    localparam int TERMS     = 12;   // Taylor degree of exp on the reduced range
    localparam int APB_AW    = 4;

    // Request kinds
    localparam logic [1:0] KIND_LOAD_FACTOR = 2'd0;
    localparam logic [1:0] KIND_LOAD_ASSET  = 2'd1;
    localparam logic [1:0] KIND_RESTART     = 2'd2;
    localparam logic [1:0] KIND_STEP        = 2'd3;

    // Register indexes
    localparam logic [1:0] REG_DRIFT_MODE = 2'd0;
    localparam logic [1:0] REG_RATE       = 2'd1;
    localparam logic [1:0] REG_STEP_LEN   = 2'd2;
    localparam logic [1:0] REG_ROOT_STEP  = 2'd3;

    // ln2 in Q1.30 and 2^48/ln2_q30 rounded, for the exponent split
    localparam logic [29:0]        LN2_Q30   = 30'd744261118;
    localparam logic signed [30:0] LN2_S     = 31'sd744261118;
    localparam logic signed [19:0] LN2_RECIP = 20'sd378194;
    localparam logic [36:0]        TERM_CAP  = 37'h10_0000_0000; // 64.0 in Q.30
    localparam logic [30:0]        ONE_Q30   = 31'h4000_0000;    // 1.0 in Q.30

    typedef struct packed {
        logic [1:0]         kind;
        logic [1:0]         asset;
        logic [1:0]         column;
        logic signed [31:0] factor_value;
        logic [31:0]        spot_value;
        logic [30:0]        vol_value;
        logic signed [31:0] drift_value;
        logic signed [15:0] normal_0;
        logic signed [15:0] normal_1;
        logic signed [15:0] normal_2;
        logic signed [15:0] normal_3;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  asset_out;
        logic [31:0] price;
        logic [15:0] step_number;
        logic        saturated;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic               drift_mode;
        logic signed [31:0] rate;
        logic [31:0]        step_length;
        logic [31:0]        root_step_length;
    } cfg_t;

    typedef struct packed {
        logic     load_factor;
        logic     load_asset;
        logic     restart;
        logic     step;
        in_item_t item;
    } lane_cmd_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] price;
        logic        saturated;
    } lane_res_t;

    // floor((2^32-1)/i): reciprocal for the Taylor term divide
    function automatic logic [31:0] term_recip(input logic [3:0] i);
        logic [31:0] m;
        case (i)
            4'd1:    m = 32'd4294967295;
            4'd2:    m = 32'd2147483647;
            4'd3:    m = 32'd1431655765;
            4'd4:    m = 32'd1073741823;
            4'd5:    m = 32'd858993459;
            4'd6:    m = 32'd715827882;
            4'd7:    m = 32'd613566756;
            4'd8:    m = 32'd536870911;
            4'd9:    m = 32'd477218588;
            4'd10:   m = 32'd429496729;
            4'd11:   m = 32'd390451572;
            4'd12:   m = 32'd357913941;
            default: m = 32'd0;
        endcase
        return m;
    endfunction

endpackage

>>> src/cgbm_lane.sv
// ----------------------------------------------------------------------------
// cgbm_lane
// One asset: holds its stores, sums correlation products, and runs the step
// sequence on a shared 32x32 multiplier (exponent terms, exp, price update).
// ----------------------------------------------------------------------------
module cgbm_lane
    import cgbm_pkg::*;
#(
    parameter int LANE_IDX = 0
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  cfg_t      cfg,
    input  lane_cmd_t cmd,
    input  logic      ack,
    output lane_res_t res
);

    typedef enum logic [4:0] {
        L_IDLE, L_LG, L_SQ, L_SRT, L_T1, L_T2, L_X, L_K, L_R, L_FIX,
        L_TA, L_TB, L_TC, L_PR, L_SH, L_DONE
    } lane_state_t;

    lane_state_t        state_reg;
    logic signed [31:0] f_reg [NORMALS];
    logic signed [15:0] z_reg [NORMALS];
    logic [31:0]        spot_reg;
    logic [30:0]        vol_reg;
    logic signed [31:0] drift_reg;
    logic [31:0]        price_reg;
    logic               sat_reg;
    logic [1:0]         j_reg;
    logic signed [49:0] lg_reg;
    logic [30:0]        half_reg;
    logic [38:0]        srt_reg;
    logic [31:0]        dmag_reg;
    logic               dneg_reg;
    logic [48:0]        lmag_reg;
    logic               lneg_reg;
    logic signed [37:0] t1_reg;
    logic [1:0]         pi_reg;
    logic [89:0]        acc_reg;
    logic signed [38:0] x_reg;
    logic signed [10:0] k0_reg;
    logic signed [31:0] r0_reg;
    logic signed [10:0] k_reg;
    logic [29:0]        r_reg;
    logic [30:0]        t_reg;
    logic [31:0]        e_reg;
    logic [3:0]         i_reg;
    logic [30:0]        v_reg;
    logic [30:0]        q_reg;
    logic [63:0]        prod_reg;

    logic [31:0]        mul_a, mul_b;
    logic [63:0]        mul_p;
    logic signed [47:0] pz;
    logic signed [31:0] mu;
    logic signed [33:0] diff;
    logic [39:0]        t1_raw;
    logic [36:0]        t1_cap;
    logic [47:0]        t2_raw;
    logic [36:0]        t2_cap;
    logic signed [37:0] t2_s;
    logic signed [32:0] xs;
    logic signed [52:0] kp;
    logic signed [41:0] kl;
    logic signed [41:0] r0_full;
    logic [34:0]        qi;
    logic [34:0]        rem;
    logic [30:0]        tnew;
    logic signed [11:0] sh;
    logic [11:0]        nsh;
    logic [63:0]        down;
    logic [63:0]        chk;
    logic [31:0]        np;
    logic               nsat;

    // Shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            L_SQ: begin
                mul_a = {1'b0, vol_reg};
                mul_b = {1'b0, vol_reg};
            end
            L_SRT: begin
                mul_a = {1'b0, vol_reg};
                mul_b = cfg.root_step_length;
            end
            L_T1: begin
                mul_a = dmag_reg;
                mul_b = cfg.step_length;
            end
            L_T2: begin
                mul_a = pi_reg[0] ? {15'd0, lmag_reg[48:32]} : lmag_reg[31:0];
                mul_b = pi_reg[1] ? {25'd0, srt_reg[38:32]} : srt_reg[31:0];
            end
            L_TA: begin
                mul_a = {1'b0, t_reg};
                mul_b = {2'b0, r_reg};
            end
            L_TB: begin
                mul_a = {1'b0, v_reg};
                mul_b = term_recip(i_reg);
            end
            L_PR: begin
                mul_a = price_reg;
                mul_b = e_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

    // Correlation product, one column per cycle
    assign pz = f_reg[j_reg] * z_reg[j_reg];

    // Drift minus half variance, magnitudes for the sign-magnitude products
    assign mu   = cfg.drift_mode ? drift_reg : cfg.rate;
    assign diff = {{2{mu[31]}}, mu} - {3'b0, half_reg};

    // Clip the two exponent terms at 64.0
    assign t1_raw = mul_p[63:24];
    assign t1_cap = (t1_raw > {3'b0, TERM_CAP}) ? TERM_CAP : t1_raw[36:0];
    assign t2_raw = acc_reg[89:42];
    assign t2_cap = (t2_raw > {11'b0, TERM_CAP}) ? TERM_CAP : t2_raw[36:0];
    assign t2_s   = lneg_reg ? -$signed({1'b0, t2_cap}) : $signed({1'b0, t2_cap});

    // Exponent split: k estimate by reciprocal, then remainder
    assign xs      = 33'(x_reg >>> 6);
    assign kp      = xs * LN2_RECIP;
    assign kl      = k0_reg * LN2_S;
    assign r0_full = 42'(x_reg) - kl;

    // Term divide correction
    assign qi   = {4'd0, q_reg} * {31'd0, i_reg};
    assign rem  = {4'd0, v_reg} - qi;
    assign tnew = (rem >= {31'd0, i_reg}) ? q_reg + 31'd1 : q_reg;

    // Scale by 2^k and saturate
    assign sh   = 12'sd30 - 12'(k_reg);
    assign nsh  = 12'(-sh);
    assign down = prod_reg >> sh[5:0];
    assign chk  = prod_reg >> (6'd32 - {1'b0, nsh[4:0]});

    always_comb begin
        np   = '0;
        nsat = 1'b0;
        if (prod_reg == '0) begin
            np = '0;
        end else if (sh > 12'sd63) begin
            np = '0;
        end else if (sh >= 12'sd0) begin
            if (down[63:32] != '0) begin
                np   = '1;
                nsat = 1'b1;
            end else begin
                np = down[31:0];
            end
        end else if (nsh >= 12'd32 || chk != '0) begin
            np   = '1;
            nsat = 1'b1;
        end else begin
            np = 32'(prod_reg << nsh[4:0]);
        end
    end

    // Sequencer and stores
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_IDLE;
            for (int n = 0; n < NORMALS; n++) begin
                f_reg[n] <= '0;
            end
            spot_reg  <= '0;
            vol_reg   <= '0;
            drift_reg <= '0;
            price_reg <= '0;
            sat_reg   <= 1'b0;
        end else begin
            case (state_reg)
                L_IDLE: begin
                    if (cmd.load_factor && cmd.item.asset == ASSET_W'(LANE_IDX)
                        && cmd.item.column <= cmd.item.asset) begin
                        f_reg[cmd.item.column] <= cmd.item.factor_value;
                    end
                    if (cmd.load_asset && cmd.item.asset == ASSET_W'(LANE_IDX)) begin
                        spot_reg  <= cmd.item.spot_value;
                        vol_reg   <= cmd.item.vol_value;
                        drift_reg <= cmd.item.drift_value;
                    end
                    if (cmd.restart) begin
                        price_reg <= spot_reg;
                    end
                    if (cmd.step) begin
                        z_reg[0]  <= cmd.item.normal_0;
                        z_reg[1]  <= cmd.item.normal_1;
                        z_reg[2]  <= cmd.item.normal_2;
                        z_reg[3]  <= cmd.item.normal_3;
                        lg_reg    <= '0;
                        j_reg     <= '0;
                        state_reg <= L_LG;
                    end
                end
                L_LG: begin
                    lg_reg <= lg_reg + 50'(pz);
                    j_reg  <= j_reg + 2'd1;
                    if (j_reg == 2'(NORMALS - 1)) begin
                        state_reg <= L_SQ;
                    end
                end
                L_SQ: begin
                    half_reg  <= mul_p[61:31];
                    state_reg <= L_SRT;
                end
                L_SRT: begin
                    srt_reg   <= mul_p[62:24];
                    dneg_reg  <= diff[33];
                    dmag_reg  <= diff[33] ? 32'(-diff) : diff[31:0];
                    lneg_reg  <= lg_reg[49];
                    lmag_reg  <= lg_reg[49] ? 49'(-lg_reg) : lg_reg[48:0];
                    state_reg <= L_T1;
                end
                L_T1: begin
                    t1_reg    <= dneg_reg ? -$signed({1'b0, t1_cap}) : $signed({1'b0, t1_cap});
                    acc_reg   <= '0;
                    pi_reg    <= '0;
                    state_reg <= L_T2;
                end
                L_T2: begin
                    case (pi_reg)
                        2'd0:    acc_reg <= acc_reg + {26'd0, mul_p};
                        2'd3:    acc_reg <= acc_reg + ({26'd0, mul_p} << 64);
                        default: acc_reg <= acc_reg + ({26'd0, mul_p} << 32);
                    endcase
                    pi_reg <= pi_reg + 2'd1;
                    if (pi_reg == 2'd3) begin
                        state_reg <= L_X;
                    end
                end
                L_X: begin
                    x_reg     <= 39'(t1_reg) + 39'(t2_s);
                    state_reg <= L_K;
                end
                L_K: begin
                    k0_reg    <= kp[52:42];
                    state_reg <= L_R;
                end
                L_R: begin
                    r0_reg    <= r0_full[31:0];
                    state_reg <= L_FIX;
                end
                L_FIX: begin
                    if (r0_reg < 32'sd0) begin
                        k_reg <= k0_reg - 11'sd1;
                        r_reg <= 30'(r0_reg + 32'(LN2_S));
                    end else if (r0_reg >= 32'(LN2_S)) begin
                        k_reg <= k0_reg + 11'sd1;
                        r_reg <= 30'(r0_reg - 32'(LN2_S));
                    end else begin
                        k_reg <= k0_reg;
                        r_reg <= r0_reg[29:0];
                    end
                    t_reg     <= ONE_Q30;
                    e_reg     <= {1'b0, ONE_Q30};
                    i_reg     <= 4'd1;
                    state_reg <= L_TA;
                end
                L_TA: begin
                    v_reg     <= mul_p[60:30];
                    state_reg <= L_TB;
                end
                L_TB: begin
                    q_reg     <= mul_p[62:32];
                    state_reg <= L_TC;
                end
                L_TC: begin
                    t_reg <= tnew;
                    e_reg <= e_reg + {1'b0, tnew};
                    i_reg <= i_reg + 4'd1;
                    if (i_reg == 4'(TERMS)) begin
                        state_reg <= L_PR;
                    end else begin
                        state_reg <= L_TA;
                    end
                end
                L_PR: begin
                    prod_reg  <= mul_p;
                    state_reg <= L_SH;
                end
                L_SH: begin
                    price_reg <= np;
                    sat_reg   <= nsat;
                    state_reg <= L_DONE;
                end
                L_DONE: begin
                    if (ack) begin
                        state_reg <= L_IDLE;
                    end
                end
                default: state_reg <= L_IDLE;
            endcase
        end
    end

    assign res.busy      = (state_reg != L_IDLE);
    assign res.done      = (state_reg == L_DONE);
    assign res.price     = price_reg;
    assign res.saturated = sat_reg;

    // Merge only takes results that are finished
    a_ack_done: assert property (@(posedge aclk) disable iff (!aresetn)
        ack |-> state_reg == L_DONE)
        else $error("lane acknowledged while not done");

    // A step started from idle keeps the lane busy
    a_step_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == L_IDLE && cmd.step) |=> res.busy)
        else $error("step did not start lane");

    // Reduced argument lies in [0, ln2)
    a_red_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == L_TA |-> r_reg < LN2_Q30)
        else $error("exp argument out of range");

    // Term index stays within the Taylor degree
    a_term_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == L_TB |-> (i_reg >= 4'd1 && i_reg <= 4'(TERMS)))
        else $error("term index out of range");

endmodule

>>> src/cgbm_merge.sv
// ----------------------------------------------------------------------------
// cgbm_merge
// Gathers the lane prices once all lanes finish and sends them out one
// asset at a time through an output register.
// ----------------------------------------------------------------------------
module cgbm_merge
    import cgbm_pkg::*;
#(
    parameter int LANES = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  lane_res_t   res [LANES],
    input  logic [15:0] step_count,
    output logic        ack,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data
);

    localparam int IDX_W = (LANES > 1) ? $clog2(LANES) : 1;

    logic [31:0]      price_buf [LANES];
    logic             sat_buf   [LANES];
    logic             full_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [15:0]      step_reg;
    logic             valid_reg;
    out_item_t        data_reg;
    logic [LANES-1:0] done_vec;
    logic             load_out;
    logic             is_last;

    always_comb begin
        for (int n = 0; n < LANES; n++) begin
            done_vec[n] = res[n].done;
        end
    end

    assign ack      = (&done_vec) && !full_reg;
    assign load_out = full_reg && (!valid_reg || m_ready);
    assign is_last  = (idx_reg == IDX_W'(LANES - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg  <= 1'b0;
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            // capture a finished step
            if (ack) begin
                for (int n = 0; n < LANES; n++) begin
                    price_buf[n] <= res[n].price;
                    sat_buf[n]   <= res[n].saturated;
                end
                step_reg <= step_count;
                full_reg <= 1'b1;
                idx_reg  <= '0;
            end
            // feed the output register
            if (load_out) begin
                data_reg.asset_out   <= ASSET_W'(idx_reg);
                data_reg.price       <= price_buf[idx_reg];
                data_reg.step_number <= step_reg;
                data_reg.saturated   <= sat_buf[idx_reg];
                data_reg.last        <= is_last;
                valid_reg            <= 1'b1;
                idx_reg              <= IDX_W'(idx_reg + 1'b1);
                if (is_last) begin
                    full_reg <= 1'b0;
                end
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

    // A capture never overwrites results still being sent
    a_no_clobber: assert property (@(posedge aclk) disable iff (!aresetn)
        ack |-> !full_reg)
        else $error("capture over pending results");

    // The final asset of a step empties the buffer
    a_last_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_out && is_last) |=> !full_reg)
        else $error("buffer not released after last asset");

    // Results leave in order starting from the first asset
    a_first_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        ack |=> idx_reg == '0)
        else $error("output index not reset on capture");

endmodule

>>> src/correlated_gbm_path_step.sv
// ----------------------------------------------------------------------------
// correlated_gbm_path_step
// One time step of a correlated multi-asset geometric Brownian motion.
// ----------------------------------------------------------------------------
// Load, load-asset and restart requests are applied on acceptance and leave
// the lanes idle. A step request runs every asset, up to four, in its own
// lane at the same time; each lane sums the correlation products, uses one
// 32x32 multiplier for the exponent terms, splits the exponent, and reuses
// it for a degree-12 Taylor series and the price scaling; the prices are then
// gathered into the output buffer. The next request is taken as soon as the
// lanes hand off, while the prices of the previous step are still being sent,
// one asset per cycle while m_ready holds, last flagged on the final asset.
// Write registers through the APB port only while idle; it is not enforced.
// ----------------------------------------------------------------------------
module correlated_gbm_path_step
    import cgbm_pkg::*;
#(
    parameter int ASSETS = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_item_t          s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_item_t         m_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int LANES = (ASSETS < NORMALS) ? ASSETS : NORMALS;

    cfg_t        cfg_reg;
    logic [15:0] step_cnt_reg;
    lane_cmd_t   cmd;
    lane_res_t   res [LANES];
    logic [LANES-1:0] busy_vec;
    logic        accept;
    logic        ack;
    logic        wr_en;
    logic [1:0]  reg_idx;

    // Register port
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_DRIFT_MODE: cfg_reg.drift_mode       <= pwdata[0];
                REG_RATE:       cfg_reg.rate             <= pwdata;
                REG_STEP_LEN:   cfg_reg.step_length      <= pwdata;
                REG_ROOT_STEP:  cfg_reg.root_step_length <= pwdata;
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_DRIFT_MODE: prdata = {31'd0, cfg_reg.drift_mode};
            REG_RATE:       prdata = cfg_reg.rate;
            REG_STEP_LEN:   prdata = cfg_reg.step_length;
            REG_ROOT_STEP:  prdata = cfg_reg.root_step_length;
            default:        prdata = '0;
        endcase
    end

    // Request decode; lanes take requests only when all are idle
    always_comb begin
        for (int n = 0; n < LANES; n++) begin
            busy_vec[n] = res[n].busy;
        end
    end

    assign s_ready = ~|busy_vec;
    assign accept  = s_valid && s_ready;

    assign cmd.load_factor = accept && (s_data.kind == KIND_LOAD_FACTOR);
    assign cmd.load_asset  = accept && (s_data.kind == KIND_LOAD_ASSET);
    assign cmd.restart     = accept && (s_data.kind == KIND_RESTART);
    assign cmd.step        = accept && (s_data.kind == KIND_STEP);
    assign cmd.item        = s_data;

    // Step counter, value after the step goes with its prices
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_cnt_reg <= '0;
        end else if (cmd.restart) begin
            step_cnt_reg <= '0;
        end else if (cmd.step) begin
            step_cnt_reg <= step_cnt_reg + 16'd1;
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        cgbm_lane #(
            .LANE_IDX (g)
        ) u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cfg     (cfg_reg),
            .cmd     (cmd),
            .ack     (ack),
            .res     (res[g])
        );
    end

    cgbm_merge #(
        .LANES (LANES)
    ) u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .res        (res),
        .step_count (step_cnt_reg),
        .ack        (ack),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule
